[src/ljs_pkg.sv]
`timescale 1ns / 1ps
// Shared codes, widths and bundle types of the link join supervisor.
// Depends on nothing; used by every other file in src.
package ljs_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int COUNT_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CONNECT_TIMEOUT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_ATTEMPTS = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOST_GRACE = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_APPLY_DELAY = 8'd3;

   localparam logic [TIMER_WIDTH-1:0] RST_CONNECT_TIMEOUT = 16'd15000;
   localparam logic [COUNT_WIDTH-1:0] RST_MAX_ATTEMPTS = 8'd2;
   localparam logic [TIMER_WIDTH-1:0] RST_LOST_GRACE = 16'd10000;
   localparam logic [TIMER_WIDTH-1:0] RST_APPLY_DELAY = 16'd500;

   // input operations
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_JOIN = 2'd2;
   localparam logic [1:0] OP_FORGET = 2'd3;

   // sampled link status
   localparam logic [2:0] LS_CONNECTED = 3'd0;
   localparam logic [2:0] LS_NOT_FOUND = 3'd1;
   localparam logic [2:0] LS_AUTH_FAILED = 3'd2;
   localparam logic [2:0] LS_CONN_LOST = 3'd3;

   // phases
   localparam logic [1:0] PH_AP = 2'd0;
   localparam logic [1:0] PH_CONN = 2'd1;
   localparam logic [1:0] PH_STA = 2'd2;

   // actions
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_AP = 2'd1;
   localparam logic [1:0] ACT_CONNECT = 2'd2;
   localparam logic [1:0] ACT_JOINED = 2'd3;

   // pending request kinds
   localparam logic [1:0] KIND_IDLE = 2'd0;
   localparam logic [1:0] KIND_JOIN = 2'd1;
   localparam logic [1:0] KIND_FORGET = 2'd2;
   localparam logic [1:0] KIND_JOIN_BLANK = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
   localparam logic [2:0] ERR_WRONG_PASSWORD = 3'd2;
   localparam logic [2:0] ERR_CONN_LOST = 3'd3;
   localparam logic [2:0] ERR_NO_ANSWER = 3'd4;
   localparam logic [2:0] ERR_LOST_NET = 3'd5;

   typedef struct packed {
      logic [TIMER_WIDTH-1:0] connect_timeout;
      logic [COUNT_WIDTH-1:0] max_attempts;
      logic [TIMER_WIDTH-1:0] lost_grace;
      logic [TIMER_WIDTH-1:0] apply_delay;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] link_status;
      logic network_present;
   } item_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] action;
      logic [2:0] error_code;
      logic [COUNT_WIDTH-1:0] attempt_count;
      logic applying;
      logic changed;
   } result_type;

endpackage

[src/ljs_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the link join supervisor.
// Depends on ljs_pkg.
module ljs_cfg_regs (
   input  logic clock,
   input  logic reset,
   input  logic csr_wen,
   input  logic [ljs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ljs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output ljs_pkg::cfg_type cfg
);

   ljs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connect_timeout <= ljs_pkg::RST_CONNECT_TIMEOUT;
         cfg_ff.max_attempts <= ljs_pkg::RST_MAX_ATTEMPTS;
         cfg_ff.lost_grace <= ljs_pkg::RST_LOST_GRACE;
         cfg_ff.apply_delay <= ljs_pkg::RST_APPLY_DELAY;
      end else if (csr_wen) begin
         unique case (csr_index)
            ljs_pkg::REG_CONNECT_TIMEOUT: cfg_ff.connect_timeout <= csr_wdata;
            ljs_pkg::REG_MAX_ATTEMPTS:
               cfg_ff.max_attempts <= csr_wdata[ljs_pkg::COUNT_WIDTH-1:0];
            ljs_pkg::REG_LOST_GRACE: cfg_ff.lost_grace <= csr_wdata;
            ljs_pkg::REG_APPLY_DELAY: cfg_ff.apply_delay <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/ljs_core.sv]
`timescale 1ns / 1ps
// Supervisor state and its single-pass next-state logic; forms one result.
// Depends on ljs_pkg.
module ljs_core (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  ljs_pkg::item_type item,
   input  ljs_pkg::cfg_type cfg,
   output ljs_pkg::result_type result
);

   logic [1:0] phase_ff, phase_in;
   logic [1:0] pending_kind_ff, pending_kind_in;
   logic [ljs_pkg::TIMER_WIDTH-1:0] pending_age_ff, pending_age_in;
   logic [ljs_pkg::TIMER_WIDTH-1:0] connect_age_ff, connect_age_in;
   logic loss_running_ff, loss_running_in;
   logic [ljs_pkg::TIMER_WIDTH-1:0] loss_age_ff, loss_age_in;
   logic [ljs_pkg::COUNT_WIDTH-1:0] attempts_ff, attempts_in;
   logic [2:0] last_error_ff, last_error_in;
   logic network_known_ff, network_known_in;
   logic [1:0] action;

   function automatic logic [ljs_pkg::TIMER_WIDTH-1:0] sat_inc(
      input logic [ljs_pkg::TIMER_WIDTH-1:0] v);
      sat_inc = (v == ljs_pkg::TIMER_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [2:0] fail_code(input logic [2:0] status);
      case (status)
         ljs_pkg::LS_NOT_FOUND: fail_code = ljs_pkg::ERR_NOT_FOUND;
         ljs_pkg::LS_AUTH_FAILED: fail_code = ljs_pkg::ERR_WRONG_PASSWORD;
         ljs_pkg::LS_CONN_LOST: fail_code = ljs_pkg::ERR_CONN_LOST;
         default: fail_code = ljs_pkg::ERR_NO_ANSWER;
      endcase
   endfunction

   always_comb begin
      logic [ljs_pkg::COUNT_WIDTH-1:0] att_inc;
      phase_in = phase_ff;
      pending_kind_in = pending_kind_ff;
      pending_age_in = pending_age_ff;
      connect_age_in = connect_age_ff;
      loss_running_in = loss_running_ff;
      loss_age_in = loss_age_ff;
      attempts_in = attempts_ff;
      last_error_in = last_error_ff;
      network_known_in = network_known_ff;
      action = ljs_pkg::ACT_NONE;
      att_inc = (attempts_ff == ljs_pkg::COUNT_MAX) ? attempts_ff : attempts_ff + 1'b1;

      unique case (item.op)
         ljs_pkg::OP_TICK: begin
            if (pending_kind_ff != ljs_pkg::KIND_IDLE) pending_age_in = sat_inc(pending_age_ff);
            if (phase_ff == ljs_pkg::PH_CONN) connect_age_in = sat_inc(connect_age_ff);
            if (loss_running_ff) loss_age_in = sat_inc(loss_age_ff);

            if (pending_kind_ff != ljs_pkg::KIND_IDLE && pending_age_in >= cfg.apply_delay) begin
               pending_kind_in = ljs_pkg::KIND_IDLE;
               pending_age_in = '0;
               last_error_in = ljs_pkg::ERR_NONE;
               loss_running_in = 1'b0;
               loss_age_in = '0;
               if (pending_kind_ff == ljs_pkg::KIND_FORGET) begin
                  network_known_in = 1'b0;
                  phase_in = ljs_pkg::PH_AP;
                  action = ljs_pkg::ACT_AP;
               end else begin
                  network_known_in = (pending_kind_ff == ljs_pkg::KIND_JOIN);
                  attempts_in = '0;
                  phase_in = ljs_pkg::PH_CONN;
                  connect_age_in = '0;
                  action = ljs_pkg::ACT_CONNECT;
               end
            end else if (phase_ff == ljs_pkg::PH_CONN) begin
               if (item.link_status == ljs_pkg::LS_CONNECTED) begin
                  phase_in = ljs_pkg::PH_STA;
                  last_error_in = ljs_pkg::ERR_NONE;
                  attempts_in = '0;
                  loss_running_in = 1'b0;
                  loss_age_in = '0;
                  action = ljs_pkg::ACT_JOINED;
               end else if (connect_age_in >= cfg.connect_timeout) begin
                  last_error_in = fail_code(item.link_status);
                  attempts_in = att_inc;
                  loss_running_in = 1'b0;
                  loss_age_in = '0;
                  if (att_inc < cfg.max_attempts) begin
                     phase_in = ljs_pkg::PH_CONN;
                     connect_age_in = '0;
                     action = ljs_pkg::ACT_CONNECT;
                  end else begin
                     phase_in = ljs_pkg::PH_AP;
                     action = ljs_pkg::ACT_AP;
                  end
               end
            end else if (phase_ff == ljs_pkg::PH_STA) begin
               if (item.link_status == ljs_pkg::LS_CONNECTED) begin
                  loss_running_in = 1'b0;
                  loss_age_in = '0;
               end else if (!loss_running_ff) begin
                  loss_running_in = 1'b1;
                  loss_age_in = '0;
               end else if (loss_age_in >= cfg.lost_grace) begin
                  last_error_in = ljs_pkg::ERR_LOST_NET;
                  phase_in = ljs_pkg::PH_AP;
                  loss_running_in = 1'b0;
                  loss_age_in = '0;
                  action = ljs_pkg::ACT_AP;
               end
            end
         end
         ljs_pkg::OP_START: begin
            network_known_in = item.network_present;
            loss_running_in = 1'b0;
            loss_age_in = '0;
            if (item.network_present) begin
               phase_in = ljs_pkg::PH_CONN;
               connect_age_in = '0;
               action = ljs_pkg::ACT_CONNECT;
            end else begin
               phase_in = ljs_pkg::PH_AP;
               action = ljs_pkg::ACT_AP;
            end
         end
         ljs_pkg::OP_JOIN: begin
            pending_kind_in = item.network_present ? ljs_pkg::KIND_JOIN
                                                   : ljs_pkg::KIND_JOIN_BLANK;
            pending_age_in = '0;
         end
         default: begin
            pending_kind_in = ljs_pkg::KIND_FORGET;
            pending_age_in = '0;
         end
      endcase

      result.phase = phase_in;
      result.action = action;
      result.error_code = last_error_in;
      result.attempt_count = attempts_in;
      result.applying = (pending_kind_in != ljs_pkg::KIND_IDLE);
      result.changed = (action != ljs_pkg::ACT_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ljs_pkg::PH_AP;
         pending_kind_ff <= ljs_pkg::KIND_IDLE;
         pending_age_ff <= '0;
         connect_age_ff <= '0;
         loss_running_ff <= 1'b0;
         loss_age_ff <= '0;
         attempts_ff <= '0;
         last_error_ff <= ljs_pkg::ERR_NONE;
         network_known_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         pending_kind_ff <= pending_kind_in;
         pending_age_ff <= pending_age_in;
         connect_age_ff <= connect_age_in;
         loss_running_ff <= loss_running_in;
         loss_age_ff <= loss_age_in;
         attempts_ff <= attempts_in;
         last_error_ff <= last_error_in;
         network_known_ff <= network_known_in;
      end
   end

endmodule

[src/link_join_supervisor_unit.sv]
`timescale 1ns / 1ps
// Link join supervisor top level: input register, supervisor core, result register.
// A request is held in the input register, and the core's result in the result register.
// Throughput: one transaction per cycle unless rsp_tready stalls, set by the single-pass core update.
// Reset (synchronous, active high): access point phase, no pending request,
// timers and counters cleared, configuration at its defaults.
// Depends on ljs_pkg, ljs_cfg_regs, ljs_core.
module link_join_supervisor_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [2:0] link_status, [3] network_present
   input  logic [1:0] req_tuser,   // [1:0] op
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // [1:0] phase, [3:2] action, [6:4] error_code,
                                   // [14:7] attempt_count, [15] applying, [16] changed
   input  logic csr_wen,
   input  logic [ljs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ljs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   ljs_pkg::cfg_type cfg;
   ljs_pkg::item_type item_ff;
   ljs_pkg::result_type result, result_ff;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic req_fire;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.op <= req_tuser;
         item_ff.link_status <= req_tdata[2:0];
         item_ff.network_present <= req_tdata[3];
      end
      if (advance) result_ff <= result;
   end

   ljs_cfg_regs u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   ljs_core u_core (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .item(item_ff),
      .cfg(cfg),
      .result(result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, result_ff.changed, result_ff.applying,
                       result_ff.attempt_count, result_ff.error_code,
                       result_ff.action, result_ff.phase};

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for link_join_supervisor_unit: a directed table, then random
// phases under several register settings, checked against an in-bench predictor.
// Depends on ljs_pkg and the link_join_supervisor_unit RTL.
module tb;
   import ljs_pkg::*;

   localparam logic [2:0] LS_OTHER = 3'd4;
   localparam logic [2:0] LS_RESERVED = 3'd7;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 8'd200;
   localparam result_type NO_WANT = '0;
   localparam int PLAN_LEN = 34;

   typedef struct {
      bit csr;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0] val;
      logic [1:0] op;
      logic [2:0] ls;
      logic np;
      bit typed;
      result_type want;
   } step_row;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic csr_wen;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   link_join_supervisor_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   cfg_type cfg;
   logic [1:0] sv_phase;
   logic [1:0] sv_pending;
   logic [TIMER_WIDTH-1:0] pend_age;
   logic [TIMER_WIDTH-1:0] conn_age;
   logic [TIMER_WIDTH-1:0] loss_age;
   logic loss_on;
   logic [COUNT_WIDTH-1:0] tries;
   logic [2:0] last_err;
   logic known;

   result_type expected_reports[$];
   int errors = 0;
   int checked = 0;
   int joins = 0;
   int fallbacks = 0;
   int settings_used = 0;
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   step_row plan [PLAN_LEN] = '{
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 1, '{PH_AP, ACT_NONE, ERR_NONE, 0, 0, 0}},
      '{0, 0, 0, OP_START, LS_CONNECTED, 0, 1, '{PH_AP, ACT_AP, ERR_NONE, 0, 0, 1}},
      '{0, 0, 0, OP_START, LS_CONNECTED, 1, 1, '{PH_CONN, ACT_CONNECT, ERR_NONE, 0, 0, 1}},
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 1, '{PH_STA, ACT_JOINED, ERR_NONE, 0, 0, 1}},
      '{0, 0, 0, OP_TICK, LS_RESERVED, 1, 1, '{PH_STA, ACT_NONE, ERR_NONE, 0, 0, 0}},
      '{1, REG_CONNECT_TIMEOUT, 16'd0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_MAX_ATTEMPTS, 16'd0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_LOST_GRACE, 16'd0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_APPLY_DELAY, 16'd0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_UNUSED, 16'd5, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONN_LOST, 0, 1, '{PH_AP, ACT_AP, ERR_LOST_NET, 0, 0, 1}},
      '{0, 0, 0, OP_JOIN, LS_CONNECTED, 0, 1, '{PH_AP, ACT_NONE, ERR_LOST_NET, 0, 1, 0}},
      '{0, 0, 0, OP_TICK, LS_NOT_FOUND, 0, 1, '{PH_CONN, ACT_CONNECT, ERR_NONE, 0, 0, 1}},
      '{0, 0, 0, OP_TICK, LS_AUTH_FAILED, 0, 1,
        '{PH_AP, ACT_AP, ERR_WRONG_PASSWORD, 1, 0, 1}},
      '{1, REG_MAX_ATTEMPTS, 16'd3, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_CONNECT_TIMEOUT, 16'd2, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_APPLY_DELAY, 16'd1, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{1, REG_LOST_GRACE, 16'd2, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_START, LS_CONNECTED, 1, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_NOT_FOUND, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_NOT_FOUND, 0, 1,
        '{PH_CONN, ACT_CONNECT, ERR_NOT_FOUND, 2, 0, 1}},
      '{0, 0, 0, OP_TICK, LS_OTHER, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_OTHER, 0, 1, '{PH_AP, ACT_AP, ERR_NO_ANSWER, 3, 0, 1}},
      '{0, 0, 0, OP_FORGET, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_JOIN, LS_CONNECTED, 1, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONN_LOST, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_AUTH_FAILED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_AUTH_FAILED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_AUTH_FAILED, 0, 1, '{PH_AP, ACT_AP, ERR_LOST_NET, 0, 0, 1}},
      '{0, 0, 0, OP_FORGET, LS_CONNECTED, 0, 0, NO_WANT},
      '{0, 0, 0, OP_TICK, LS_CONNECTED, 0, 0, NO_WANT}
   };

   function automatic logic [TIMER_WIDTH-1:0] timer_bump(logic [TIMER_WIDTH-1:0] v);
      return (v == TIMER_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [1:0] enter_ap();
      sv_phase = PH_AP;
      loss_on = 1'b0;
      loss_age = '0;
      return ACT_AP;
   endfunction

   function automatic logic [1:0] enter_connect();
      sv_phase = PH_CONN;
      conn_age = '0;
      loss_on = 1'b0;
      loss_age = '0;
      return ACT_CONNECT;
   endfunction

   function automatic result_type advance_supervisor(item_type it);
      logic [1:0] act;
      logic [1:0] kind;
      result_type r;
      act = ACT_NONE;
      case (it.op)
         OP_TICK: begin
            if (sv_pending != KIND_IDLE) pend_age = timer_bump(pend_age);
            if (sv_phase == PH_CONN) conn_age = timer_bump(conn_age);
            if (loss_on) loss_age = timer_bump(loss_age);
            if (sv_pending != KIND_IDLE && pend_age >= cfg.apply_delay) begin
               kind = sv_pending;
               sv_pending = KIND_IDLE;
               pend_age = '0;
               last_err = ERR_NONE;
               if (kind == KIND_FORGET) begin
                  known = 1'b0;
                  act = enter_ap();
               end else begin
                  known = (kind == KIND_JOIN);
                  tries = '0;
                  act = enter_connect();
               end
            end else if (sv_phase == PH_CONN) begin
               if (it.link_status == LS_CONNECTED) begin
                  sv_phase = PH_STA;
                  last_err = ERR_NONE;
                  tries = '0;
                  loss_on = 1'b0;
                  loss_age = '0;
                  act = ACT_JOINED;
               end else if (conn_age >= cfg.connect_timeout) begin
                  case (it.link_status)
                     LS_NOT_FOUND: last_err = ERR_NOT_FOUND;
                     LS_AUTH_FAILED: last_err = ERR_WRONG_PASSWORD;
                     LS_CONN_LOST: last_err = ERR_CONN_LOST;
                     default: last_err = ERR_NO_ANSWER;
                  endcase
                  if (tries != COUNT_MAX) tries = tries + 1'b1;
                  if (tries < cfg.max_attempts) act = enter_connect();
                  else act = enter_ap();
               end
            end else if (sv_phase == PH_STA) begin
               if (it.link_status == LS_CONNECTED) begin
                  loss_on = 1'b0;
                  loss_age = '0;
               end else if (!loss_on) begin
                  loss_on = 1'b1;
                  loss_age = '0;
               end else if (loss_age >= cfg.lost_grace) begin
                  last_err = ERR_LOST_NET;
                  act = enter_ap();
               end
            end
         end
         OP_START: begin
            known = it.network_present;
            if (it.network_present) act = enter_connect();
            else act = enter_ap();
         end
         OP_JOIN: begin
            sv_pending = it.network_present ? KIND_JOIN : KIND_JOIN_BLANK;
            pend_age = '0;
         end
         default: begin
            sv_pending = KIND_FORGET;
            pend_age = '0;
         end
      endcase
      r.phase = sv_phase;
      r.action = act;
      r.error_code = last_err;
      r.attempt_count = tries;
      r.applying = (sv_pending != KIND_IDLE);
      r.changed = (act != ACT_NONE);
      return r;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) it.op = OP_TICK;
      else if (pick < 80) it.op = OP_START;
      else if (pick < 91) it.op = OP_JOIN;
      else it.op = OP_FORGET;
      it.link_status = ($urandom_range(0, 99) < 55) ? LS_CONNECTED : 3'($urandom_range(1, 7));
      if (it.op == OP_START) it.network_present = ($urandom_range(0, 4) != 0);
      else it.network_present = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic offer(item_type it, bit typed, result_type want);
      int gap;
      result_type predicted;
      gap = (idle_on && hold_left == 0 && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, it.network_present, it.link_status};
      req_tuser <= it.op;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = advance_supervisor(it);
      expected_reports.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_CONNECT_TIMEOUT: cfg.connect_timeout = val;
         REG_MAX_ATTEMPTS: cfg.max_attempts = val[COUNT_WIDTH-1:0];
         REG_LOST_GRACE: cfg.lost_grace = val;
         REG_APPLY_DELAY: cfg.apply_delay = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int timeout, int attempts, int grace, int delay);
      wait_idle();
      write_csr(REG_CONNECT_TIMEOUT, 16'(timeout));
      write_csr(REG_MAX_ATTEMPTS, 16'(attempts));
      write_csr(REG_LOST_GRACE, 16'(grace));
      write_csr(REG_APPLY_DELAY, 16'(delay));
      settings_used++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.phase = rsp_tdata[1:0];
         got.action = rsp_tdata[3:2];
         got.error_code = rsp_tdata[6:4];
         got.attempt_count = rsp_tdata[14:7];
         got.applying = rsp_tdata[15];
         got.changed = rsp_tdata[16];
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transaction: %h", rsp_tdata);
         end else begin
            want = expected_reports.pop_front();
            checked++;
            if (want.action == ACT_JOINED) joins++;
            if (want.action == ACT_AP) fallbacks++;
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at %0t: expected phase %0d action %0d err %0d tries %0d %b%b",
                           $realtime, want.phase, want.action, want.error_code,
                           want.attempt_count, want.applying, want.changed);
                  $display("             actual   phase %0d action %0d err %0d tries %0d %b%b",
                           got.phase, got.action, got.error_code, got.attempt_count,
                           got.applying, got.changed);
               end
            end
         end
      end
   end

   initial begin : stimulus
      item_type it;
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_TICK;
      csr_wen = 1'b0;
      csr_index = REG_CONNECT_TIMEOUT;
      csr_wdata = '0;
      cfg.connect_timeout = RST_CONNECT_TIMEOUT;
      cfg.max_attempts = RST_MAX_ATTEMPTS;
      cfg.lost_grace = RST_LOST_GRACE;
      cfg.apply_delay = RST_APPLY_DELAY;
      sv_phase = PH_AP;
      sv_pending = KIND_IDLE;
      pend_age = '0;
      conn_age = '0;
      loss_age = '0;
      loss_on = 1'b0;
      tries = '0;
      last_err = ERR_NONE;
      known = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].csr) begin
            wait_idle();
            write_csr(plan[i].idx, plan[i].val);
         end else begin
            it.op = plan[i].op;
            it.link_status = plan[i].ls;
            it.network_present = plan[i].np;
            offer(it, plan[i].typed, plan[i].want);
         end
      end

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            5: configure(1, COUNT_MAX, $urandom_range(0, 10), $urandom_range(0, 8));
            6: begin
               configure(TIMER_MAX, COUNT_MAX, TIMER_MAX, TIMER_MAX);
               write_csr(REG_UNUSED, 16'($urandom));
            end
            7: configure(1, 1, 1, 0);
            default: configure($urandom_range(0, 10), $urandom_range(0, 4),
                               $urandom_range(0, 10), $urandom_range(0, 8));
         endcase
         if (ph == 0) hold_req = 1'b1;
         if (ph == 8) idle_on = 1'b0;
         if (ph == 5) begin
            // retry until the attempt counter runs out
            it.op = OP_START;
            it.link_status = LS_CONNECTED;
            it.network_present = 1'b1;
            offer(it, 1'b0, NO_WANT);
            repeat (256) begin
               it.op = OP_TICK;
               it.link_status = 3'($urandom_range(1, 7));
               it.network_present = 1'($urandom_range(0, 1));
               offer(it, 1'b0, NO_WANT);
            end
         end else begin
            n = (ph == 6) ? 30 : (ph == 7) ? 40 : 50;
            repeat (n) offer(random_item(), 1'b0, NO_WANT);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d response transactions under %0d register settings", checked,
               settings_used);
      $display("saw %0d joins and %0d falls back to access point", joins, fallbacks);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end
endmodule
